FILE: rtl/core/stpt_pkg.sv
// ----------------------------------------------------------------------------
// stpt_pkg
// Shared types and fixed widths of the stereo point triangulator.
// ----------------------------------------------------------------------------
package stpt_pkg;

    // field widths
    localparam int COEF_W      = 40;
    localparam int PIX_W       = 16;
    localparam int IDX_W       = 5;
    localparam int OUT_W       = 32;
    localparam int SLOTS       = 24;
    localparam int QUEUE_DEPTH = 4;

    // normalised mantissa width of the least-squares system
    localparam int MANT_BITS = 14;
    // raw system entries: difference of a pixel times coefficient product and a scaled coefficient
    localparam int A_W       = COEF_W + PIX_W + 1;
    localparam int SH_W      = 6;
    localparam int M_W       = MANT_BITS + 1;
    // normal matrix entries, cofactors, determinant and numerators
    localparam int N_W       = 2 * MANT_BITS + 4;
    localparam int C_W       = 2 * N_W;
    localparam int D_W       = C_W + N_W;
    localparam int HALF_W    = 32;
    localparam int DIV_STEPS = OUT_W;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_SOLVE = 1'b1
    } cmd_t;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [OUT_W-1:0]  coord_t;
    typedef logic signed [A_W-1:0]    araw_t;

    // one triangulate word after the system build
    typedef struct packed
    {
        araw_t [11:0] a;
        araw_t [3:0]  b;
    } system_t;

    // per coordinate division state travelling down the divider
    typedef struct packed
    {
        logic                     singular;
        logic [D_W-1:0]           mdet;
        logic [2:0]               neg;
        logic [2:0]               sat;
        logic [2:0][D_W-1:0]      rem;
        logic [2:0][HALF_W-1:0]   low;
        logic [2:0][HALF_W-1:0]   quo;
    } div_t;

endpackage

FILE: rtl/core/stpt_if.sv
// ----------------------------------------------------------------------------
// stpt_in_if / stpt_out_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface stpt_in_if;
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [stpt_pkg::IDX_W-1:0] coef_index;
    stpt_pkg::coef_t       coef_value;
    stpt_pkg::pix_t        left_x;
    stpt_pkg::pix_t        left_y;
    stpt_pkg::pix_t        right_x;
    stpt_pkg::pix_t        right_y;

    modport source
    (
        output valid, command, coef_index, coef_value, left_x, left_y, right_x, right_y,
        input  ready
    );
    modport sink
    (
        input  valid, command, coef_index, coef_value, left_x, left_y, right_x, right_y,
        output ready
    );
endinterface

interface stpt_out_if;
    logic             valid;
    logic             ready;
    stpt_pkg::coord_t point_x;
    stpt_pkg::coord_t point_y;
    stpt_pkg::coord_t point_z;
    logic             singular;
    logic             saturated;

    modport source
    (
        output valid, point_x, point_y, point_z, singular, saturated,
        input  ready
    );
    modport sink
    (
        input  valid, point_x, point_y, point_z, singular, saturated,
        output ready
    );
endinterface

FILE: rtl/core/stpt_front.sv
// ----------------------------------------------------------------------------
// stpt_front
// Takes command words, holds the projection coefficients and builds the
// 4x3 system and right-hand side for each triangulate word.
// ----------------------------------------------------------------------------
module stpt_front #(
    parameter int PIXEL_FRAC_BITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    stpt_in_if.sink           cmd,
    output logic              push_valid,
    output stpt_pkg::system_t push_data,
    input  logic              push_ready
);

    stpt_pkg::coef_t coef_reg [stpt_pkg::SLOTS];
    stpt_pkg::araw_t pix_ext  [4];
    logic            write_hit;

    // writes never need the queue but share its ready to keep the order
    assign cmd.ready  = push_ready;
    assign push_valid = cmd.valid && (cmd.command == stpt_pkg::CMD_SOLVE);
    assign write_hit  = cmd.valid && cmd.ready && (cmd.command == stpt_pkg::CMD_WRITE)
                        && (cmd.coef_index < stpt_pkg::IDX_W'(stpt_pkg::SLOTS));

    // coefficient store, slots beyond the last are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < stpt_pkg::SLOTS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (write_hit)
        begin
            coef_reg[cmd.coef_index] <= cmd.coef_value;
        end
    end

    // rows in order right x, right y, left x, left y
    assign pix_ext[0] = stpt_pkg::araw_t'({1'b0, cmd.right_x});
    assign pix_ext[1] = stpt_pkg::araw_t'({1'b0, cmd.right_y});
    assign pix_ext[2] = stpt_pkg::araw_t'({1'b0, cmd.left_x});
    assign pix_ext[3] = stpt_pkg::araw_t'({1'b0, cmd.left_y});

    // a = p * P[2][j] - P[k][j], b = P[k][3] - p * P[2][3], same fixed scale
    always_comb
    begin
        push_data = '0;
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                push_data.a[k*3+j] =
                    pix_ext[k] * stpt_pkg::araw_t'(coef_reg[(k/2)*12 + 8 + j])
                    - (stpt_pkg::araw_t'(coef_reg[(k/2)*12 + (k%2)*4 + j])
                       <<< PIXEL_FRAC_BITS);
            end
            push_data.b[k] =
                (stpt_pkg::araw_t'(coef_reg[(k/2)*12 + (k%2)*4 + 3]) <<< PIXEL_FRAC_BITS)
                - pix_ext[k] * stpt_pkg::araw_t'(coef_reg[(k/2)*12 + 11]);
        end
    end

endmodule

FILE: rtl/core/stpt_queue.sv
// ----------------------------------------------------------------------------
// stpt_queue
// Short first-in first-out queue between the front and the solver.
// ----------------------------------------------------------------------------
module stpt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  stpt_pkg::system_t push_data,
    output logic              push_ready,
    output logic              pop_valid,
    output stpt_pkg::system_t pop_data,
    input  logic              pop
);

    localparam int PTR_W = $clog2(stpt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    stpt_pkg::system_t slot_reg [stpt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != CNT_W'(stpt_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/stpt_solver.sv
// ----------------------------------------------------------------------------
// stpt_solver
// Normalises the system, forms the normal equations, cofactors, determinant
// and numerators, and prepares the scaled numerators for division.
// ----------------------------------------------------------------------------
module stpt_solver #(
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  stpt_pkg::system_t in_data,
    output logic              out_valid,
    output stpt_pkg::div_t    out_data
);

    localparam int E_W    = stpt_pkg::SH_W + 2;
    localparam int WIDE_W = stpt_pkg::D_W + OUT_FRAC_BITS + (1 << stpt_pkg::SH_W);
    localparam int STAGES = 9;
    localparam int A_W    = stpt_pkg::A_W;
    localparam int M_W    = stpt_pkg::M_W;
    localparam int N_W    = stpt_pkg::N_W;
    localparam int C_W    = stpt_pkg::C_W;
    localparam int D_W    = stpt_pkg::D_W;
    localparam int HW     = stpt_pkg::HALF_W;

    function automatic logic [stpt_pkg::SH_W-1:0] norm_shift(input logic [A_W-1:0] m);
        logic [stpt_pkg::SH_W-1:0] s;
        s = '0;
        for (int i = stpt_pkg::MANT_BITS; i < A_W; i++)
        begin
            if (m[i])
            begin
                s = stpt_pkg::SH_W'(i - stpt_pkg::MANT_BITS + 1);
            end
        end
        return s;
    endfunction

    function automatic logic signed [M_W-1:0] shrink(input logic [A_W-1:0] m, input logic neg,
                                                      input logic [stpt_pkg::SH_W-1:0] sh);
        logic [A_W-1:0]         t;
        logic signed [M_W-1:0]  v;
        t = m >> sh;
        v = $signed({1'b0, t[stpt_pkg::MANT_BITS-1:0]});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [C_W-1:0] mul_nn(input logic signed [N_W-1:0] x,
                                                      input logic signed [N_W-1:0] y);
        return C_W'(x) * C_W'(y);
    endfunction

    function automatic int nxt(input int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

    logic [STAGES-1:0] v_reg;

    // stage 1: magnitudes and their or
    logic [A_W-1:0]         amag1_reg [12];
    logic [A_W-1:0]         bmag1_reg [4];
    logic [11:0]            asgn1_reg;
    logic [3:0]             bsgn1_reg;
    logic [A_W-1:0]         aor1_reg;
    logic [A_W-1:0]         bor1_reg;
    logic [A_W-1:0]         amag1_next [12];
    logic [A_W-1:0]         bmag1_next [4];
    logic [A_W-1:0]         aor1_next;
    logic [A_W-1:0]         bor1_next;
    // stage 2: normalised entries and output exponent
    logic signed [M_W-1:0]  am2_reg [12];
    logic signed [M_W-1:0]  bm2_reg [4];
    logic signed [E_W-1:0]  e_reg [6];
    logic [stpt_pkg::SH_W-1:0] sa2;
    logic [stpt_pkg::SH_W-1:0] sb2;
    // stage 3: normal matrix and right-hand side
    logic signed [N_W-1:0]  n3_reg [3][3];
    logic signed [N_W-1:0]  r3_reg [3];
    logic signed [N_W-1:0]  n3_next [3][3];
    logic signed [N_W-1:0]  r3_next [3];
    // stage 4: cofactors
    logic signed [N_W-1:0]  n4_reg [3];
    logic signed [N_W-1:0]  r4_reg [3];
    logic signed [C_W-1:0]  c4_reg [3][3];
    // stage 5: partial products
    logic signed [D_W-1:0]  dh5_reg [3];
    logic signed [D_W-1:0]  dl5_reg [3];
    logic signed [D_W-1:0]  nh5_reg [3][3];
    logic signed [D_W-1:0]  nl5_reg [3][3];
    // stage 6: determinant and numerators
    logic signed [D_W-1:0]  det6_reg;
    logic signed [D_W-1:0]  num6_reg [3];
    logic signed [D_W-1:0]  det6_next;
    logic signed [D_W-1:0]  num6_next [3];
    // stage 7: magnitudes and signs
    logic [D_W-1:0]         mdet7_reg;
    logic [D_W-1:0]         nmag7_reg [3];
    logic [2:0]             neg7_reg;
    logic                   sing7_reg;
    // stage 8: scaled numerators
    logic [D_W-1:0]         mdet8_reg;
    logic [WIDE_W-1:0]      wide8_reg [3];
    logic [2:0]             neg8_reg;
    logic                   sing8_reg;
    logic [WIDE_W-1:0]      wide8_next [3];
    // stage 9: divider entry
    stpt_pkg::div_t         div9_reg;
    stpt_pkg::div_t         div9_next;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    // magnitude and or of each group
    always_comb
    begin
        aor1_next = '0;
        bor1_next = '0;
        for (int i = 0; i < 12; i++)
        begin
            amag1_next[i] = in_data.a[i][A_W-1] ? A_W'(-in_data.a[i]) : A_W'(in_data.a[i]);
            aor1_next     = aor1_next | amag1_next[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            bmag1_next[i] = in_data.b[i][A_W-1] ? A_W'(-in_data.b[i]) : A_W'(in_data.b[i]);
            bor1_next     = bor1_next | bmag1_next[i];
        end
    end

    assign sa2 = norm_shift(aor1_reg);
    assign sb2 = norm_shift(bor1_reg);

    // normal equations
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r3_next[i] = '0;
            for (int k = 0; k < 4; k++)
            begin
                r3_next[i] = r3_next[i] + N_W'(am2_reg[k*3+i]) * N_W'(bm2_reg[k]);
            end
            for (int j = 0; j < 3; j++)
            begin
                n3_next[i][j] = '0;
                for (int k = 0; k < 4; k++)
                begin
                    n3_next[i][j] = n3_next[i][j]
                                    + N_W'(am2_reg[k*3+i]) * N_W'(am2_reg[k*3+j]);
                end
            end
        end
    end

    // determinant and numerator sums from the partial products
    always_comb
    begin
        det6_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det6_next = det6_next + (dh5_reg[j] <<< HW) + dl5_reg[j];
        end
        for (int i = 0; i < 3; i++)
        begin
            num6_next[i] = '0;
            for (int j = 0; j < 3; j++)
            begin
                num6_next[i] = num6_next[i] + (nh5_reg[i][j] <<< HW) + nl5_reg[i][j];
            end
        end
    end

    // exponent shift of the numerator magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!e_reg[5][E_W-1])
            begin
                wide8_next[i] = WIDE_W'(nmag7_reg[i]) << e_reg[5];
            end
            else
            begin
                wide8_next[i] = WIDE_W'(nmag7_reg[i]) >> (-e_reg[5]);
            end
        end
    end

    // split into saturation test and divider start state
    always_comb
    begin
        div9_next          = '0;
        div9_next.singular = sing8_reg;
        div9_next.mdet     = mdet8_reg;
        div9_next.neg      = neg8_reg;
        for (int i = 0; i < 3; i++)
        begin
            div9_next.sat[i] = wide8_reg[i] >= WIDE_W'({mdet8_reg, HW'(0)});
            div9_next.rem[i] = wide8_reg[i][D_W+HW-1:HW];
            div9_next.low[i] = wide8_reg[i][HW-1:0];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 12; i++)
            begin
                amag1_reg[i] <= amag1_next[i];
                asgn1_reg[i] <= in_data.a[i][A_W-1];
                am2_reg[i]   <= shrink(amag1_reg[i], asgn1_reg[i], sa2);
            end
            for (int i = 0; i < 4; i++)
            begin
                bmag1_reg[i] <= bmag1_next[i];
                bsgn1_reg[i] <= in_data.b[i][A_W-1];
                bm2_reg[i]   <= shrink(bmag1_reg[i], bsgn1_reg[i], sb2);
            end
            aor1_reg <= aor1_next;
            bor1_reg <= bor1_next;

            e_reg[0] <= $signed(E_W'(OUT_FRAC_BITS)) + $signed(E_W'(sb2)) - $signed(E_W'(sa2));
            for (int s = 1; s < 6; s++)
            begin
                e_reg[s] <= e_reg[s-1];
            end

            n3_reg <= n3_next;
            r3_reg <= r3_next;

            for (int i = 0; i < 3; i++)
            begin
                n4_reg[i] <= n3_reg[0][i];
                r4_reg[i] <= r3_reg[i];
                for (int j = 0; j < 3; j++)
                begin
                    c4_reg[i][j] <= mul_nn(n3_reg[nxt(i)][nxt(j)], n3_reg[nxt(nxt(i))][nxt(nxt(j))])
                                  - mul_nn(n3_reg[nxt(i)][nxt(nxt(j))], n3_reg[nxt(nxt(i))][nxt(j)]);
                end
            end

            // products cut at the cofactor's half word
            for (int j = 0; j < 3; j++)
            begin
                dh5_reg[j] <= D_W'(n4_reg[j]) * D_W'($signed(c4_reg[0][j][C_W-1:HW]));
                dl5_reg[j] <= D_W'(n4_reg[j]) * D_W'($signed({1'b0, c4_reg[0][j][HW-1:0]}));
                for (int i = 0; i < 3; i++)
                begin
                    nh5_reg[i][j] <= D_W'(r4_reg[j]) * D_W'($signed(c4_reg[j][i][C_W-1:HW]));
                    nl5_reg[i][j] <= D_W'(r4_reg[j])
                                     * D_W'($signed({1'b0, c4_reg[j][i][HW-1:0]}));
                end
            end

            det6_reg <= det6_next;
            num6_reg <= num6_next;

            mdet7_reg <= det6_reg[D_W-1] ? D_W'(-det6_reg) : D_W'(det6_reg);
            sing7_reg <= det6_reg == '0;
            for (int i = 0; i < 3; i++)
            begin
                nmag7_reg[i] <= num6_reg[i][D_W-1] ? D_W'(-num6_reg[i]) : D_W'(num6_reg[i]);
                neg7_reg[i]  <= num6_reg[i][D_W-1] != det6_reg[D_W-1];
            end

            mdet8_reg <= mdet7_reg;
            sing8_reg <= sing7_reg;
            neg8_reg  <= neg7_reg;
            wide8_reg <= wide8_next;

            div9_reg <= div9_next;
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_data  = div9_reg;

endmodule

FILE: rtl/core/stpt_divider.sv
// ----------------------------------------------------------------------------
// stpt_divider
// Restoring division pipeline, one quotient bit per stage for all three
// coordinates against the shared determinant magnitude.
// ----------------------------------------------------------------------------
module stpt_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  stpt_pkg::div_t in_data,
    output logic           out_valid,
    output stpt_pkg::div_t out_data
);

    localparam int STEPS = stpt_pkg::DIV_STEPS;
    localparam int D_W   = stpt_pkg::D_W;
    localparam int HW    = stpt_pkg::HALF_W;

    function automatic stpt_pkg::div_t div_step(input stpt_pkg::div_t d);
        stpt_pkg::div_t r;
        logic [D_W:0]   t;
        logic [D_W:0]   diff;
        r = d;
        for (int i = 0; i < 3; i++)
        begin
            t    = {d.rem[i], d.low[i][HW-1]};
            diff = t - {1'b0, d.mdet};
            if (t >= {1'b0, d.mdet})
            begin
                r.rem[i] = diff[D_W-1:0];
                r.quo[i] = {d.quo[i][HW-2:0], 1'b1};
            end
            else
            begin
                r.rem[i] = t[D_W-1:0];
                r.quo[i] = {d.quo[i][HW-2:0], 1'b0};
            end
            r.low[i] = {d.low[i][HW-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [STEPS-1:0] valid_reg;
    stpt_pkg::div_t   stage_reg [STEPS];

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
        end
    end

    // one quotient bit per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= div_step(in_data);
            for (int s = 1; s < STEPS; s++)
            begin
                stage_reg[s] <= div_step(stage_reg[s-1]);
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_data  = stage_reg[STEPS-1];

endmodule

FILE: rtl/core/stereo_point_triangulator.sv
// ----------------------------------------------------------------------------
// stereo_point_triangulator
// Least-squares triangulation of a left/right pixel pair into a 3-D point.
// ----------------------------------------------------------------------------
// One word is taken every cycle while the queue has room: a coefficient write
// completes in that cycle and returns nothing, a triangulate word passes
// through the queue slot, nine solver stages, thirty-two divider stages and
// the output register before its result word shows, the depth being set by
// the one-bit-per-stage restoring divider. Throughput is one triangulate word
// per cycle; a stalled result holds the whole back end while the four-entry
// queue keeps taking words. Coefficients are Q24.16 but their scale cancels,
// pixels carry PIXEL_FRAC_BITS fraction bits and points OUT_FRAC_BITS.
// ----------------------------------------------------------------------------
module stereo_point_triangulator #(
    parameter int PIXEL_FRAC_BITS = 4,
    parameter int OUT_FRAC_BITS   = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    stpt_in_if.sink    cmd,
    stpt_out_if.source res
);

    localparam int HW = stpt_pkg::HALF_W;

    logic              push_valid;
    logic              push_ready;
    stpt_pkg::system_t push_data;
    logic              pop_valid;
    stpt_pkg::system_t pop_data;
    logic              en;
    logic              div_in_valid;
    stpt_pkg::div_t    div_in;
    logic              div_out_valid;
    stpt_pkg::div_t    div_out;

    logic              res_valid_reg;
    stpt_pkg::coord_t  point_reg [3];
    logic              singular_reg;
    logic              saturated_reg;
    stpt_pkg::coord_t  point_next [3];
    logic              saturated_next;

    // back end moves when the output register is free or being taken
    assign en = !res_valid_reg || res.ready;

    stpt_front #(
        .PIXEL_FRAC_BITS (PIXEL_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    stpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (en)
    );

    stpt_solver #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_solver (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pop_valid),
        .in_data   (pop_data),
        .out_valid (div_in_valid),
        .out_data  (div_in)
    );

    stpt_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_in_valid),
        .in_data   (div_in),
        .out_valid (div_out_valid),
        .out_data  (div_out)
    );

    // clip, apply sign, blank singular systems
    always_comb
    begin
        logic [HW-1:0] limit;
        logic [HW-1:0] mag;
        logic          clip;
        saturated_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            limit = div_out.neg[i] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
            clip  = div_out.sat[i] || (div_out.quo[i] > limit);
            mag   = clip ? limit : div_out.quo[i];
            if (div_out.singular)
            begin
                point_next[i] = '0;
            end
            else
            begin
                point_next[i]  = div_out.neg[i] ? $signed(-mag) : $signed(mag);
                saturated_next = saturated_next | clip;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            point_reg     <= point_next;
            singular_reg  <= div_out.singular;
            saturated_reg <= saturated_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.point_x   = point_reg[0];
    assign res.point_y   = point_reg[1];
    assign res.point_z   = point_reg[2];
    assign res.singular  = singular_reg;
    assign res.saturated = saturated_reg;

endmodule

FILE: rtl/core/stpt_checker.sv
// ----------------------------------------------------------------------------
// stpt_checker
// Port-level checks of the triangulator, bound to the top level.
// ----------------------------------------------------------------------------
module stpt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input logic             cmd_command,
    input logic             res_valid,
    input logic             res_ready,
    input stpt_pkg::coord_t point_x,
    input stpt_pkg::coord_t point_y,
    input stpt_pkg::coord_t point_z,
    input logic             singular,
    input logic             saturated
);

    logic [7:0] pending_reg;
    logic       solve_in;
    logic       word_out;

    assign solve_in = cmd_valid && cmd_ready && (cmd_command == stpt_pkg::CMD_SOLVE);
    assign word_out = res_valid && res_ready;

    // triangulate words still owed a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (solve_in && !word_out)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (word_out && !solve_in)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // no result while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result word during reset");

    // every result answers an earlier triangulate word
    a_owed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != '0)
        else $error("result word without a triangulate word");

    // a singular system reports a zero point and no clipping
    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && singular |-> point_x == '0 && point_y == '0 && point_z == '0
                                  && !saturated)
        else $error("singular result carries data");

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(point_x) && $stable(point_y)
                                    && $stable(point_z) && $stable(singular)
                                    && $stable(saturated))
        else $error("stalled result word changed");

endmodule

bind stereo_point_triangulator stpt_checker u_stpt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_command (cmd.command),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .point_x     (res.point_x),
    .point_y     (res.point_y),
    .point_z     (res.point_z),
    .singular    (res.singular),
    .saturated   (res.saturated)
);
